// ===== src/hvd_pkg.sv =====
// shared constants, types and functions for the haversine distance pipeline
package hvd_pkg;

    localparam int ITERATION_STEPS = 24;
    localparam int SQRT_STEPS = 32;
    localparam int LANES = 4;
    localparam int LAT_CYCLES = 42 + 2 * ITERATION_STEPS;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    localparam logic [31:0] DIV45_RECIP = 32'd3054198967;
    localparam logic [5:0] DIV45 = 6'd45;
    localparam logic [24:0] FRAC_RECIP = 25'd23860930;
    localparam logic [17:0] ROUND_HALF = 18'd22;

    localparam logic [32:0] DIST_MULT = 33'd5246834913;
    localparam logic [16:0] DIST_MULT_HI = DIST_MULT[32:16];
    localparam logic [15:0] DIST_MULT_LO = DIST_MULT[15:0];
    localparam logic [23:0] HALF_CIRC = 24'd5123862;

    typedef logic signed [33:0] rot_t;
    typedef logic signed [34:0] vec_t;
    typedef logic signed [31:0] q30_t;

    // atan(2^-k) in turns, 2^32 per revolution
    function automatic rot_t atan_turn(input logic [4:0] k);
        rot_t r;
        unique case (k)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // q30 product rounded half up
    function automatic q30_t mul_q30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = 64'(a) * 64'(b);
        s = (p + 64'sd536870912) >>> 30;
        return s[31:0];
    endfunction

    function automatic q30_t clamp_q30(input rot_t v);
        q30_t r;
        if (v > ONE_Q30) begin
            r = 32'sd1073741824;
        end else if (v < -ONE_Q30) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/haversine_distance.sv =====
// haversine great circle distance, fully pipelined
//
// command port: a word (lat_a, lon_a, lat_b, lon_b) is taken at every clock
// edge with start high; busy is always low, so a new word may enter each cycle.
// the result word appears on distance with done high for exactly one cycle,
// in order. throughput is one word per cycle; the pipeline is made of the
// angle conversion (4 stages), the rotation cordic (one stage per step), the
// product stages (3), the square root units (one stage per result bit, 32)
// and the vectoring cordic (one stage per step), plus the trig, scaling and
// output registers.
// the receiver cannot hold results off, and the pipeline never stalls.
// reset clears only the valid bits: nothing is reported until new words enter.
// distance is in 1/256 km and saturates at half the circumference.
module haversine_distance
    import hvd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] lat_a,
    input  logic signed [24:0] lon_a,
    input  logic signed [23:0] lat_b,
    input  logic signed [24:0] lon_b,
    output logic               done,
    output logic        [22:0] distance
);

    logic [LAT_CYCLES-1:0] vld_reg, vld_next;

    logic [24:0] mag1_reg [LANES], mag1_next [LANES];
    logic        neg1_reg [LANES], neg1_next [LANES];
    logic [24:0] mag2_reg [LANES];
    logic        neg2_reg [LANES];
    logic [19:0] qd2_reg [LANES], qd2_next [LANES];
    logic        neg3_reg [LANES];
    logic [19:0] qd3_reg [LANES];
    logic [11:0] frac3_reg [LANES], frac3_next [LANES];

    rot_t cx_reg [ITERATION_STEPS+1][LANES], cx_next [ITERATION_STEPS+1][LANES];
    rot_t cy_reg [ITERATION_STEPS+1][LANES], cy_next [ITERATION_STEPS+1][LANES];
    rot_t cz_reg [ITERATION_STEPS+1][LANES], cz_next [ITERATION_STEPS+1][LANES];
    logic flip_reg [ITERATION_STEPS+1][LANES], flip_next [ITERATION_STEPS+1][LANES];

    q30_t trig_reg [LANES], trig_next [LANES];
    q30_t uu_reg, uu_next, vv_reg, vv_next, cc_reg, cc_next;
    q30_t uu2_reg, t2_reg, t2_next;

    logic [63:0] sn_reg [SQRT_STEPS+1][2], sn_next [SQRT_STEPS+1][2];
    logic [63:0] sr_reg [SQRT_STEPS+1][2], sr_next [SQRT_STEPS+1][2];

    vec_t vx_reg [1:ITERATION_STEPS], vx_next [1:ITERATION_STEPS];
    vec_t vy_reg [1:ITERATION_STEPS], vy_next [1:ITERATION_STEPS];
    rot_t vz_reg [1:ITERATION_STEPS], vz_next [1:ITERATION_STEPS];

    logic [47:0] ph_reg, ph_next;
    logic [46:0] pl_reg, pl_next;
    logic [22:0] dist_reg, dist_next;

    assign busy = 1'b0;
    assign done = vld_reg[LAT_CYCLES-1];
    assign distance = dist_reg;
    assign vld_next = {vld_reg[LAT_CYCLES-2:0], start & ~busy};

    // signed differences and doubled latitudes, then magnitude and sign
    always_comb
    begin
        logic signed [25:0] d [LANES];
        d[0] = {{2{lat_b[23]}}, lat_b} - {{2{lat_a[23]}}, lat_a};
        d[1] = {lon_b[24], lon_b} - {lon_a[24], lon_a};
        d[2] = {lat_a[23], lat_a, 1'b0};
        d[3] = {lat_b[23], lat_b, 1'b0};
        for (int l = 0; l < LANES; l++)
        begin
            logic signed [25:0] m;
            m = d[l][25] ? -d[l] : d[l];
            neg1_next[l] = d[l][25];
            mag1_next[l] = m[24:0];
        end
    end

    // divide by 45: coarse quotient, then remainder lookup by reciprocal
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [56:0] p;
            logic [24:0] rem;
            logic [17:0] num;
            logic [42:0] fp;
            p = 57'(mag1_reg[l]) * 57'(DIV45_RECIP);
            qd2_next[l] = p[56:37];
            rem = mag2_reg[l] - 25'(qd2_reg[l] * 25'(DIV45));
            num = {rem[5:0], 12'b0} + ROUND_HALF;
            fp = 43'(num) * 43'(FRAC_RECIP);
            frac3_next[l] = fp[41:30];
        end
    end

    // turn angle, quadrant fold and rotation cordic
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [31:0] q, ang, hi, r;
            q = {qd3_reg[l], frac3_reg[l]};
            ang = neg3_reg[l] ? -q : q;
            hi = ang + 32'h4000_0000;
            flip_next[0][l] = hi[31];
            r = hi[31] ? ang + 32'h8000_0000 : ang;
            cz_next[0][l] = {{2{r[31]}}, r};
            cx_next[0][l] = CORDIC_GAIN;
            cy_next[0][l] = '0;
        end
        for (int s = 0; s < ITERATION_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                rot_t xs, ys, at;
                xs = cx_reg[s][l] >>> 5'(s);
                ys = cy_reg[s][l] >>> 5'(s);
                at = atan_turn(5'(s));
                flip_next[s+1][l] = flip_reg[s][l];
                if (!cz_reg[s][l][33])
                begin
                    cx_next[s+1][l] = cx_reg[s][l] - ys;
                    cy_next[s+1][l] = cy_reg[s][l] + xs;
                    cz_next[s+1][l] = cz_reg[s][l] - at;
                end
                else
                begin
                    cx_next[s+1][l] = cx_reg[s][l] + ys;
                    cy_next[s+1][l] = cy_reg[s][l] - xs;
                    cz_next[s+1][l] = cz_reg[s][l] + at;
                end
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            rot_t xf, yf;
            xf = flip_reg[ITERATION_STEPS][l] ? -cx_reg[ITERATION_STEPS][l]
                                              : cx_reg[ITERATION_STEPS][l];
            yf = flip_reg[ITERATION_STEPS][l] ? -cy_reg[ITERATION_STEPS][l]
                                              : cy_reg[ITERATION_STEPS][l];
            trig_next[l] = (l < 2) ? clamp_q30(yf) : clamp_q30(xf);
        end
    end

    // products, a, square root units
    always_comb
    begin
        logic signed [32:0] a_sum;
        logic [30:0] a_cl;
        uu_next = mul_q30(trig_reg[0], trig_reg[0]);
        vv_next = mul_q30(trig_reg[1], trig_reg[1]);
        cc_next = mul_q30(trig_reg[2], trig_reg[3]);
        t2_next = mul_q30(cc_reg, vv_reg);
        a_sum = 33'(uu2_reg) + 33'(t2_reg);
        if (a_sum[32])
        begin
            a_cl = '0;
        end
        else if (a_sum > 33'sd1073741824)
        begin
            a_cl = 31'd1073741824;
        end
        else
        begin
            a_cl = a_sum[30:0];
        end
        sn_next[0][0] = {3'b0, a_cl, 30'b0};
        sn_next[0][1] = {3'b0, 31'd1073741824 - a_cl, 30'b0};
        sr_next[0][0] = '0;
        sr_next[0][1] = '0;
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                logic [63:0] bt, tr;
                bt = 64'd1 << (62 - 2 * j);
                tr = sr_reg[j][k] + bt;
                if (sn_reg[j][k] >= tr)
                begin
                    sn_next[j+1][k] = sn_reg[j][k] - tr;
                    sr_next[j+1][k] = (sr_reg[j][k] >> 1) + bt;
                end
                else
                begin
                    sn_next[j+1][k] = sn_reg[j][k];
                    sr_next[j+1][k] = sr_reg[j][k] >> 1;
                end
            end
        end
    end

    // vectoring cordic gives asin(s) = atan2(s, c), then scale to km
    always_comb
    begin
        vec_t x, y, xs, ys;
        rot_t z, at, zc;
        logic [63:0] sum;
        for (int s = 0; s < ITERATION_STEPS; s++)
        begin
            if (s == 0)
            begin
                x = vec_t'(sr_reg[SQRT_STEPS][1][31:0]);
                y = vec_t'(sr_reg[SQRT_STEPS][0][31:0]);
                z = '0;
            end
            else
            begin
                x = vx_reg[s];
                y = vy_reg[s];
                z = vz_reg[s];
            end
            xs = x >>> 5'(s);
            ys = y >>> 5'(s);
            at = atan_turn(5'(s));
            if (!y[34] && (y != '0))
            begin
                vx_next[s+1] = x + ys;
                vy_next[s+1] = y - xs;
                vz_next[s+1] = z + at;
            end
            else
            begin
                vx_next[s+1] = x - ys;
                vy_next[s+1] = y + xs;
                vz_next[s+1] = z - at;
            end
        end
        z = vz_reg[ITERATION_STEPS];
        if (z[33])
        begin
            zc = '0;
        end
        else if (z > ONE_Q30)
        begin
            zc = ONE_Q30;
        end
        else
        begin
            zc = z;
        end
        ph_next = 48'(zc[30:0]) * 48'(DIST_MULT_HI);
        pl_next = 47'(zc[30:0]) * 47'(DIST_MULT_LO);
        sum = {ph_reg[47:0], 16'b0} + 64'(pl_reg) + (64'd1 << 39);
        if (sum[63:40] > HALF_CIRC)
        begin
            dist_next = HALF_CIRC[22:0];
        end
        else
        begin
            dist_next = sum[62:40];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mag1_reg[l] <= mag1_next[l];
            neg1_reg[l] <= neg1_next[l];
            mag2_reg[l] <= mag1_reg[l];
            neg2_reg[l] <= neg1_reg[l];
            qd2_reg[l] <= qd2_next[l];
            neg3_reg[l] <= neg2_reg[l];
            qd3_reg[l] <= qd2_reg[l];
            frac3_reg[l] <= frac3_next[l];
            trig_reg[l] <= trig_next[l];
        end
        for (int s = 0; s <= ITERATION_STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cx_reg[s][l] <= cx_next[s][l];
                cy_reg[s][l] <= cy_next[s][l];
                cz_reg[s][l] <= cz_next[s][l];
                flip_reg[s][l] <= flip_next[s][l];
            end
        end
        uu_reg <= uu_next;
        vv_reg <= vv_next;
        cc_reg <= cc_next;
        uu2_reg <= uu_reg;
        t2_reg <= t2_next;
        for (int j = 0; j <= SQRT_STEPS; j++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                sn_reg[j][k] <= sn_next[j][k];
                sr_reg[j][k] <= sr_next[j][k];
            end
        end
        for (int s = 1; s <= ITERATION_STEPS; s++)
        begin
            vx_reg[s] <= vx_next[s];
            vy_reg[s] <= vy_next[s];
            vz_reg[s] <= vz_next[s];
        end
        ph_reg <= ph_next;
        pl_reg <= pl_next;
        dist_reg <= dist_next;
    end

endmodule

// ===== tb/haversine_distance_tb.sv =====
// self-checking testbench for the haversine distance pipeline
module haversine_distance_tb;

    localparam int LAT_LIMIT = 42 + 2 * 24;
    localparam int STEPS = 24;
    localparam longint Q30 = 64'sd1073741824;
    localparam longint GAIN = 64'sd652032874;
    localparam bit [63:0] KM256_MULT = 64'd5246834913;
    localparam bit [63:0] HALF_EARTH = 64'd5123862;
    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int DEG = 65536;
    localparam longint ATAN_TURN [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    logic               done;
    logic        [22:0] distance;

    logic [22:0] pending_distance [$];
    int          fail_count;
    int          words_sent;
    int          words_checked;
    int          idle_pct;

    haversine_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .lat_a    (lat_a),
        .lon_a    (lon_a),
        .lat_b    (lat_b),
        .lon_b    (lon_b),
        .done     (done),
        .distance (distance)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit [31:0] deg_to_turns(input longint num);
        longint q;
        q = num >= 0 ? (num + 22) / 45 : -((-num + 22) / 45);
        return q[31:0];
    endfunction

    function automatic longint mul_round_q30(input longint x, input longint y);
        return (x * y + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate_sin_cos(input bit [31:0] ang, output longint sn,
                                           output longint cs);
        bit        flip;
        bit [31:0] r;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        flip = ang[31] ^ ang[30];
        r = flip ? ang + 32'h80000000 : ang;
        z = longint'($signed(r));
        x = GAIN;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> (i % 32);
            ys = y >>> (i % 32);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i % 32];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i % 32];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cs = clip(x, -Q30, Q30);
        sn = clip(y, -Q30, Q30);
    endfunction

    function automatic bit [63:0] int_sqrt(input bit [63:0] n);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [22:0] great_circle_km256(input longint la, input longint oa,
                                                       input longint lb, input longint ob);
        longint    u;
        longint    v;
        longint    c1;
        longint    c2;
        longint    unused;
        longint    hav;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        bit [63:0] d;
        rotate_sin_cos(deg_to_turns((lb - la) * 4096), u, unused);
        rotate_sin_cos(deg_to_turns((ob - oa) * 4096), v, unused);
        rotate_sin_cos(deg_to_turns(la * 8192), unused, c1);
        rotate_sin_cos(deg_to_turns(lb * 8192), unused, c2);
        hav = mul_round_q30(u, u) + mul_round_q30(mul_round_q30(c1, c2), mul_round_q30(v, v));
        hav = clip(hav, 0, Q30);
        y = int_sqrt(64'(hav) << 30);
        x = int_sqrt(64'(Q30 - hav) << 30);
        z = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> (i % 32);
            ys = y >>> (i % 32);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i % 32];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i % 32];
            end
        end
        z = clip(z, 0, Q30);
        d = (64'(z) * KM256_MULT + (64'd1 << 39)) >> 40;
        if (d > HALF_EARTH)
        begin
            d = HALF_EARTH;
        end
        return d[22:0];
    endfunction

    task automatic send_word(input int la, input int oa, input int lb, input int ob);
        logic signed [23:0] la_w;
        logic signed [24:0] oa_w;
        logic signed [23:0] lb_w;
        logic signed [24:0] ob_w;
        la_w = 24'(la);
        oa_w = 25'(oa);
        lb_w = 24'(lb);
        ob_w = 25'(ob);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        lat_a <= la_w;
        lon_a <= oa_w;
        lat_b <= lb_w;
        lon_b <= ob_w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_distance.push_back(great_circle_km256(longint'(la_w), longint'(oa_w),
                                                      longint'(lb_w), longint'(ob_w)));
        words_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_distance.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_distance.size() == 0)
            begin
                $display("%0t: unexpected word, distance %0d", $time, distance);
                fail_count++;
            end
            else
            begin
                if (distance !== pending_distance[0])
                begin
                    $display("%0t: distance expected %0d actual %0d", $time,
                             pending_distance[0], distance);
                    fail_count++;
                end
                void'(pending_distance.pop_front());
                words_checked++;
            end
        end
    end

    task automatic test_directed();
        send_word(0, 0, 0, 0);
        send_word(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_word(LAT_MAX, 0, -LAT_MAX, 0);
        send_word(0, 0, 0, LON_MAX);
        send_word(0, -LON_MAX, 0, LON_MAX);
        send_word(0, 0, 0, -LON_MAX);
        send_word(45 * DEG, 10 * DEG, -45 * DEG, -170 * DEG);
        send_word(LAT_MAX, 0, LAT_MAX, LON_MAX);
        send_word(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_word(0, 0, 1, 1);
        send_word(1, -1, -1, 1);
        send_word(32'h007fffff, 32'h00ffffff, 32'h00800000, 32'h01000000);
        send_word(32'h00800000, 32'h01000000, 32'h007fffff, 32'h00ffffff);
        send_word(32'h00ffffff, 32'h01ffffff, 32'h00000000, 32'h00000000);
        send_word(32'h00800000, 32'h01000000, 32'h00800000, 32'h01000000);
        send_word(51 * DEG, 0, 40 * DEG, -74 * DEG);
        send_word(-33 * DEG, 151 * DEG, 35 * DEG, 139 * DEG);
        send_word(30 * DEG, 0, -30 * DEG, 180 * DEG);
        send_word(89 * DEG, 12 * DEG, -89 * DEG, -168 * DEG);
        send_word(0, 90 * DEG, 0, -90 * DEG);
    endtask

    task automatic test_random(input int count);
        int la;
        int oa;
        int lb;
        int ob;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99, 0);
            la = int'($urandom_range(2 * LAT_MAX, 0)) - LAT_MAX;
            oa = int'($urandom_range(2 * LON_MAX, 0)) - LON_MAX;
            lb = int'($urandom_range(2 * LAT_MAX, 0)) - LAT_MAX;
            ob = int'($urandom_range(2 * LON_MAX, 0)) - LON_MAX;
            if (pick < 12)
            begin
                la = int'($urandom());
                oa = int'($urandom());
                lb = int'($urandom());
                ob = int'($urandom());
            end
            else if (pick < 24)
            begin
                // near antipodal pair, exercises saturation
                lb = -la + int'($urandom_range(64, 0)) - 32;
                ob = oa + (oa < 0 ? 180 * DEG : -180 * DEG) + int'($urandom_range(64, 0)) - 32;
            end
            else if (pick < 34)
            begin
                // nearly coincident points
                lb = la + int'($urandom_range(2000, 0)) - 1000;
                ob = oa + int'($urandom_range(2000, 0)) - 1000;
            end
            send_word(la, oa, lb, ob);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        fail_count = 0;
        words_sent = 0;
        words_checked = 0;
        idle_pct = 36;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        wait_drained();
        test_random(260);
        idle_pct = 55;
        test_random(260);
        wait_drained();
        idle_pct = 0;
        test_random(280);
        wait_drained();
        repeat (LAT_LIMIT + 20) @(negedge clk);
        $display("sent %0d words, checked %0d distances: poles, antipodes, coincident points,",
                 words_sent, words_checked);
        $display("full-width wrapped angles and random pairs under three idle patterns");
        if (fail_count == 0 && pending_distance.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
